// File: sv/lru_page_buffer_check_assert.svh
// Assertion macros for the LRU page buffer check block.
// Used by lru_page_buffer_check; expects clock and reset in scope.
`ifndef LRU_PAGE_BUFFER_CHECK_ASSERT_SVH
`define LRU_PAGE_BUFFER_CHECK_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LPBC_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LPBC_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: sv/lpbc_pkg.sv
// Shared types and constants for the LRU page buffer check block.
// No dependencies; imported by lpbc_cell and lru_page_buffer_check.
`default_nettype none

package lpbc_pkg;

   // Default sizes for the top level parameters
   localparam int CAPACITY_DEFAULT = 16;
   localparam int ID_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels and the register
   localparam int PAGE_ID_W   = 32;
   localparam int LIMIT_W     = 5;
   localparam int OCC_W       = 5;
   localparam int RSP_TDATA_W = 8;

   localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 5'd16;

   // Operation codes carried on req_tuser
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Commands broadcast from the controller to every cell
   typedef struct packed {
      logic capture;     // register the key compare result
      logic remove_hit;  // close the gap left by the matching entry
      logic shift_all;   // drop the oldest entry
      logic write;       // write the key at the given position
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: sv/lpbc_cell.sv
// One slot of the LRU order chain: holds a page id and its compare result.
// Depends on lpbc_pkg; instantiated in a row by lru_page_buffer_check.
`default_nettype none

module lpbc_cell import lpbc_pkg::*; #(
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT,
   parameter int CNT_W    = 5,
   parameter int INDEX    = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_cmd_type        cmd,
   input  wire logic [ID_WIDTH-1:0] key,
   input  wire logic [CNT_W-1:0]    count,
   input  wire logic [CNT_W-1:0]    wr_pos,
   input  wire logic [ID_WIDTH-1:0] next_id,
   input  wire logic                gap_prev,
   output logic      [ID_WIDTH-1:0] id_out,
   output logic                     gap_next,
   output logic                     match_out
);

   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                match_ff, match_in;
   logic                occupied, shift_here, write_here;

   // Slot holds a resident page when it lies below the fill count
   assign occupied = CNT_W'(INDEX) < count;

   // A gap opens at the matching slot and runs toward the newest end
   assign gap_next   = match_ff | gap_prev;
   assign shift_here = (cmd.remove_hit & gap_next) | cmd.shift_all;
   assign write_here = cmd.write & (CNT_W'(INDEX) == wr_pos);

   always_comb begin
      match_in = match_ff;
      if (cmd.capture) begin
         match_in = occupied & (id_ff == key);
      end
   end

   // Take the key, the neighbor's id, or hold
   always_comb begin
      id_in = id_ff;
      if (write_here) begin
         id_in = key;
      end else if (shift_here) begin
         id_in = next_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out    = id_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// File: sv/lru_page_buffer_check.sv
// Top level of the LRU page buffer check: controller and a row of order cells.
// Depends on lpbc_pkg, lpbc_cell and lru_page_buffer_check_assert.svh.
//
// Usage:
//   req channel: req_tuser is the operation (0 access, 1 clear), req_tdata the
//   page id. rsp channel: rsp_tuser is the fault flag, rsp_tdata[4:0] the
//   occupancy after the item. One result is produced for every request.
//   csr_wr_en/csr_wr_data write the page limit; write only while idle.
//   Order of work: one request is worked at a time. A clear goes from
//   transfer straight to the result; an access passes compare and update,
//   and a fault that stores the page also passes eviction. The next
//   request is taken the cycle after the result is loaded. The eviction
//   loop drops one oldest page per cycle through the cell chain.
//   Reset empties the buffer, sets the page limit to 16 and drops any
//   pending result. When the receiver stalls, the result stays in the
//   output register; a new request may be taken meanwhile, and its own
//   result waits until the output register is free.
`default_nettype none
`include "lru_page_buffer_check_assert.svh"

module lru_page_buffer_check import lpbc_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int ID_WIDTH = ID_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PAGE_ID_W-1:0]   req_tdata,   // [31:0] page_id
   input  wire logic                   req_tuser,   // [0] operation
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // [4:0] occupancy, [7:5] zero
   output logic                        rsp_tuser,   // [0] fault
   input  wire logic                   csr_wr_en,
   input  wire logic [LIMIT_W-1:0]     csr_wr_data  // [4:0] page_limit
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_COMPARE = 5'b00010,
      ST_UPDATE  = 5'b00100,
      ST_EVICT   = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [LIMIT_W-1:0]  csr_page_limit_ff, csr_page_limit_in;
   logic [ID_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                fault_ff, fault_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fault_ff, rsp_fault_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   cell_cmd_type        cmd;
   logic [CNT_W-1:0]    wr_pos;
   logic [ID_WIDTH-1:0] cell_id   [CAPACITY];
   logic [CAPACITY-1:0] cell_gap;
   logic [CAPACITY-1:0] cell_match;
   logic                any_hit;
   logic                req_xfer, rsp_load;

   assign req_xfer = req_tvalid & req_tready;
   assign any_hit  = |cell_match;
   assign rsp_load = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_tready);

   // Write the page limit register on csr_wr_en, else hold it
   always_comb begin
      csr_page_limit_in = csr_page_limit_ff;
      if (csr_wr_en) begin
         csr_page_limit_in = csr_wr_data;
      end
   end

   // Sequence one request through compare, update and eviction; a clear skips them
   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      limit_in   = limit_ff;
      count_in   = count_ff;
      fault_in   = fault_ff;
      cmd        = '0;
      wr_pos     = count_ff - CNT_W'(1);
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in = ID_WIDTH'({{ID_WIDTH{1'b0}}, req_tdata});
               if (32'(csr_page_limit_ff) > 32'(CAPACITY)) begin
                  limit_in = CNT_W'(CAPACITY);
               end else begin
                  limit_in = CNT_W'(csr_page_limit_ff);
               end
               if (req_tuser == OP_CLEAR) begin
                  count_in = '0;
                  fault_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_COMPARE;
               end
            end
         end
         ST_COMPARE: begin
            cmd.capture = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (any_hit) begin
               // Move the hit page to the newest end
               cmd.remove_hit = 1'b1;
               cmd.write      = 1'b1;
               fault_in       = 1'b0;
               state_in       = ST_FINISH;
            end else begin
               fault_in = 1'b1;
               if (limit_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_EVICT;
               end
            end
         end
         ST_EVICT: begin
            if (count_ff >= limit_ff) begin
               // Drop the oldest page
               cmd.shift_all = 1'b1;
               count_in      = count_ff - CNT_W'(1);
            end else begin
               // Append the new page
               cmd.write = 1'b1;
               wr_pos    = count_ff;
               count_in  = count_ff + CNT_W'(1);
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the output register, drop it after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_occ_in   = rsp_occ_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_fault_in = fault_ff;
         rsp_occ_in   = OCC_W'(count_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         csr_page_limit_ff <= PAGE_LIMIT_RESET;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         csr_page_limit_ff <= csr_page_limit_in;
         count_ff          <= count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      limit_ff     <= limit_in;
      fault_ff     <= fault_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   // Row of order cells, oldest at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ID_WIDTH-1:0] next_id;
      logic                gap_prev;

      if (i == CAPACITY - 1) begin : g_last
         assign next_id = key_ff;
      end else begin : g_mid
         assign next_id = cell_id[i+1];
      end

      if (i == 0) begin : g_first
         assign gap_prev = 1'b0;
      end else begin : g_rest
         assign gap_prev = cell_gap[i-1];
      end

      lpbc_cell #(
         .ID_WIDTH (ID_WIDTH),
         .CNT_W    (CNT_W),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .key       (key_ff),
         .count     (count_ff),
         .wr_pos    (wr_pos),
         .next_id   (next_id),
         .gap_prev  (gap_prev),
         .id_out    (cell_id[i]),
         .gap_next  (cell_gap[i]),
         .match_out (cell_match[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fault_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_occ_ff);

   // Fill count never passes the number of cells
   `LPBC_ASSERT(a_count_in_range, count_ff <= CNT_W'(CAPACITY), "occupancy above capacity")
   // Resident ids are unique, so at most one cell matches
   `LPBC_ASSERT(a_single_match, (state_ff != ST_UPDATE) || $onehot0(cell_match), "two cells hit")
   // Eviction only runs with a nonzero limit
   `LPBC_ASSERT(a_evict_limit, (state_ff != ST_EVICT) || (limit_ff != '0), "evict with zero limit")
   // A clear empties the buffer at once
   `LPBC_ASSERT_NEXT(a_clear_empties, req_xfer && (req_tuser == OP_CLEAR), count_ff == '0, "clear failed")

endmodule

`default_nettype wire
